FILE: rtl/servo_pulse_train_sequencer_macros.svh
// Assertion helpers shared by the sequencer modules.
`ifndef SERVO_PULSE_TRAIN_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_TRAIN_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

FILE: rtl/spts_pkg.sv
package spts_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int NUM_SLOTS    = 5;
    localparam int WIDTH_BITS   = 16;
    localparam int LEN_BITS     = 16;
    localparam int SLOT_BITS    = 3;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int RESET_COMPARE        = 625;

    localparam logic [SLOT_BITS-1:0] GAP_SLOT = 3'd4;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_SCALE_MODE   = 3'd0,
        CFG_FRAME_PERIOD = 3'd1,
        CFG_ALLOWANCE    = 3'd2,
        CFG_MIN_WIDTH    = 3'd3,
        CFG_MAX_WIDTH    = 3'd4
    } t_cfg_idx;

    typedef logic [NUM_SLOTS-1:0][LEN_BITS-1:0] t_slot_lens;

    // One queued item: either a tick or a full set of slot lengths.
    typedef struct packed {
        logic       load;
        t_slot_lens lens;
    } t_entry;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } t_q_status;

endpackage

FILE: rtl/spts_front.sv
module spts_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spts_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [spts_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_load,
    input  logic [spts_pkg::NUM_CHANNELS-1:0][spts_pkg::WIDTH_BITS-1:0] i_widths,
    input  spts_pkg::t_q_status                 i_q_status,
    output logic                                o_push,
    output spts_pkg::t_entry                    o_entry
);

    localparam int WB = spts_pkg::WIDTH_BITS;
    localparam int NC = spts_pkg::NUM_CHANNELS;
    localparam int SUM_BITS = WB + 2;

    logic          r_scale_mode;
    logic [15:0]   r_period;
    logic [7:0]    r_allowance;
    logic [15:0]   r_min_width;
    logic [15:0]   r_max_width;

    // Widths in microseconds to ticks, minus the allowance, modulo 2^16.
    function automatic logic [spts_pkg::LEN_BITS-1:0] to_ticks(
        input logic         mode,
        input logic [15:0]  us,
        input logic [7:0]   allow
    );
        logic [17:0] t;
        if (mode) begin
            t = {1'b0, us, 1'b0} + {3'b000, us[15:1]};
        end else begin
            t = {2'b00, us} + {4'b0000, us[15:2]};
        end
        t = t - {10'd0, allow};
        return t[spts_pkg::LEN_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode <= 1'b0;
            r_period     <= 16'd20000;
            r_allowance  <= 8'd8;
            r_min_width  <= 16'd1000;
            r_max_width  <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                spts_pkg::CFG_SCALE_MODE:   r_scale_mode <= i_cfg_wdata[0];
                spts_pkg::CFG_FRAME_PERIOD: r_period     <= i_cfg_wdata;
                spts_pkg::CFG_ALLOWANCE:    r_allowance  <= i_cfg_wdata[7:0];
                spts_pkg::CFG_MIN_WIDTH:    r_min_width  <= i_cfg_wdata;
                spts_pkg::CFG_MAX_WIDTH:    r_max_width  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Three stages: clamp, scale and sum, gap conversion at the queue input.
    logic                       r_a_valid, r_b_valid, r_c_valid;
    logic                       r_a_load, r_b_load, r_c_load;
    logic [NC-1:0][WB-1:0]      r_a_w, n_a_w;
    logic [NC-1:0][15:0]        r_b_len, n_b_len, r_c_len;
    logic [SUM_BITS-1:0]        r_b_sum, n_b_sum;
    logic [15:0]                r_c_diff;
    logic                       r_c_lt;
    logic                       en;

    assign en      = !r_c_valid || i_q_status.not_full;
    assign o_ready = en;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (i_widths[i] > r_max_width) begin
                n_a_w[i] = r_max_width;
            end else if (i_widths[i] < r_min_width) begin
                n_a_w[i] = r_min_width;
            end else begin
                n_a_w[i] = i_widths[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_b_len[i] = to_ticks(r_scale_mode, r_a_w[i], r_allowance);
        end
        n_b_sum = (SUM_BITS'(r_a_w[0]) + SUM_BITS'(r_a_w[1]))
                + (SUM_BITS'(r_a_w[2]) + SUM_BITS'(r_a_w[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_load <= i_load;
            r_a_w    <= n_a_w;
            r_b_load <= r_a_load;
            r_b_len  <= n_b_len;
            r_b_sum  <= n_b_sum;
            r_c_load <= r_b_load;
            r_c_len  <= r_b_len;
            r_c_lt   <= r_b_sum < SUM_BITS'(r_period);
            r_c_diff <= r_period - r_b_sum[15:0];
        end
    end

    always_comb begin
        o_push       = r_c_valid && i_q_status.not_full;
        o_entry.load = r_c_load;
        for (int i = 0; i < NC; i++) begin
            o_entry.lens[i] = r_c_len[i];
        end
        o_entry.lens[spts_pkg::GAP_SLOT] =
            r_c_lt ? to_ticks(r_scale_mode, r_c_diff, r_allowance) : '0;
    end

endmodule

FILE: rtl/spts_queue.sv
`include "servo_pulse_train_sequencer_macros.svh"

module spts_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  spts_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output spts_pkg::t_entry     o_entry,
    output spts_pkg::t_q_status  o_status
);

    localparam int DEPTH = spts_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    spts_pkg::t_entry       r_mem [DEPTH];
    logic [PTR_BITS-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]    r_count;

    assign o_status.not_full  = r_count != CNT_BITS'(DEPTH);
    assign o_status.not_empty = r_count != '0;
    assign o_entry            = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SPTS_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, o_status.not_full)
    `SPTS_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, o_status.not_empty)

endmodule

FILE: rtl/spts_back.sv
`include "servo_pulse_train_sequencer_macros.svh"

module spts_back #(
    parameter int COUNTER_BITS = spts_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spts_pkg::t_q_status               i_q_status,
    input  spts_pkg::t_entry                  i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [spts_pkg::NUM_CHANNELS-1:0] o_pins,
    output logic [spts_pkg::SLOT_BITS-1:0]    o_slot,
    output logic                              o_advanced
);

    localparam int NS = spts_pkg::NUM_SLOTS;
    localparam int SB = spts_pkg::SLOT_BITS;
    localparam int NC = spts_pkg::NUM_CHANNELS;

    logic [COUNTER_BITS-1:0]      r_tick, n_tick, tick_inc;
    logic [COUNTER_BITS-1:0]      r_compare, n_compare;
    logic [SB-1:0]                r_slot, n_slot;
    logic [NC-1:0]                r_pins, n_pins;
    spts_pkg::t_slot_lens         r_lens, n_lens;
    logic                         n_adv;
    logic                         r_out_valid;
    logic [NC-1:0]                r_o_pins;
    logic [SB-1:0]                r_o_slot;
    logic                         r_o_adv;
    logic                         match;

    assign o_pop    = i_q_status.not_empty && (!r_out_valid || i_ready);
    assign tick_inc = r_tick + 1'b1;
    assign match    = tick_inc == r_compare;

    always_comb begin
        n_tick    = r_tick;
        n_compare = r_compare;
        n_slot    = r_slot;
        n_pins    = r_pins;
        n_lens    = r_lens;
        n_adv     = 1'b0;
        if (i_entry.load) begin
            n_lens = i_entry.lens;
        end else begin
            n_tick = tick_inc;
            if (match) begin
                n_adv  = 1'b1;
                n_tick = '0;
                n_slot = r_slot + 1'b1;
                unique case (r_slot)
                    3'd0: n_pins = (r_pins & 4'b1110) | 4'b0010;
                    3'd1: n_pins = (r_pins & 4'b1101) | 4'b0100;
                    3'd2: n_pins = (r_pins & 4'b1011) | 4'b1000;
                    3'd3: n_pins = r_pins & 4'b0111;
                    default: begin
                        // The gap slot, and any stray index, restarts the frame.
                        n_pins = r_pins | 4'b0001;
                        n_slot = '0;
                    end
                endcase
                n_compare = COUNTER_BITS'(r_lens[n_slot]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_compare   <= COUNTER_BITS'(spts_pkg::RESET_COMPARE);
            r_slot      <= '0;
            r_pins      <= '0;
            r_lens      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tick    <= n_tick;
                r_compare <= n_compare;
                r_slot    <= n_slot;
                r_pins    <= n_pins;
                r_lens    <= n_lens;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_pins <= n_pins;
            r_o_slot <= n_slot;
            r_o_adv  <= n_adv;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pins     = r_o_pins;
    assign o_slot     = r_o_slot;
    assign o_advanced = r_o_adv;

    `SPTS_ASSERT_SAME(a_slot_range, i_clk, i_rst_n, 1'b1, r_slot <= spts_pkg::GAP_SLOT)
    `SPTS_ASSERT_SAME(a_one_pin_high, i_clk, i_rst_n, 1'b1, $onehot0(r_pins))
    `SPTS_ASSERT_NEXT(a_clear_on_advance, i_clk, i_rst_n, o_pop && n_adv, r_tick == '0)

endmodule

FILE: rtl/servo_pulse_train_sequencer.sv
// Servo pulse train sequencer.
// Slave stream: one item per transfer. tuser is the opcode (0 = timer tick,
// 1 = load four widths); tdata carries the four widths in microseconds.
// Master stream: one result per input item, in order, giving pin levels,
// the slot now being timed and whether this tick moved to the next slot.
// Configuration: a write strobe, a register index and 16-bit data; writes
// land at the clock edge and must be made only while no item is in
// flight; the block itself does not enforce this.
// An item passes three front stages that clamp, scale and size the gap,
// then the queue, then the timer stage that drives the output register.
// Throughput: one item per cycle while the receiver keeps up; the timer stage
// updates counter and compare value together, so ticks can arrive back to back.
// A four-entry queue sits between the front stages and the timer stage.
// When the receiver stalls, the output register holds, the queue fills and
// then s_axis_tready drops; no item is lost.
// Reset (synchronous, active low) restores the register defaults, clears
// the counter, the slot index, the slot lengths and the pins, and loads the
// compare value with 625.
module servo_pulse_train_sequencer #(
    parameter int COUNTER_BITS = spts_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spts_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [spts_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // width_a_us, width_b_us, width_c_us, width_d_us
    input  logic [63:0]                        s_axis_tdata,
    // opcode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pin_levels, active_slot, one zero pad bit
    output logic [7:0]                         m_axis_tdata,
    // slot_advanced
    output logic                               m_axis_tuser
);

    localparam int NC = spts_pkg::NUM_CHANNELS;
    localparam int WB = spts_pkg::WIDTH_BITS;

    logic [NC-1:0][WB-1:0]         widths;
    spts_pkg::t_q_status           q_status;
    spts_pkg::t_entry              push_entry, pop_entry;
    logic                          push, pop;
    logic [NC-1:0]                 pins;
    logic [spts_pkg::SLOT_BITS-1:0] slot;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            widths[i] = s_axis_tdata[i*WB +: WB];
        end
    end

    spts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_load     (s_axis_tuser),
        .i_widths   (widths),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    spts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (pop_entry),
        .o_status (q_status)
    );

    spts_back #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_entry    (pop_entry),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pins     (pins),
        .o_slot     (slot),
        .o_advanced (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, slot, pins};

endmodule
